// ----- design/vrwr_pkg.sv -----
// Shared widths, reset values, register indexes and stage records for the vertical random walk.
package vrwr_pkg;

    localparam int DEPTH_W = 32;
    localparam int CFG_W   = 31;
    localparam int RAND_W  = 16;
    localparam int IDX_W   = 2;
    localparam int IN_W    = 96;

    localparam logic [CFG_W-1:0] MIXED_LAYER_RST = 31'd10000000;
    localparam logic [CFG_W-1:0] BOTTOM_RST      = 31'd2147483647;
    localparam logic [CFG_W-1:0] AMP_RST         = 31'd0;

    typedef enum logic [IDX_W-1:0] {
        CFG_MIXED_LAYER_DEPTH = 2'd0,
        CFG_BOTTOM_DEPTH      = 2'd1,
        CFG_MIXED_STEP_AMP    = 2'd2,
        CFG_DEEP_STEP_AMP     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] mixed_layer;
        logic [CFG_W-1:0] bottom;
        logic [CFG_W-1:0] amp_mixed;
        logic [CFG_W-1:0] amp_deep;
    } t_cfg;

    typedef struct packed {
        logic        [RAND_W-1:0]  rand_place_column;
        logic        [RAND_W-1:0]  rand_place_layer;
        logic signed [RAND_W-1:0]  rand_deep;
        logic signed [RAND_W-1:0]  rand_mixed;
        logic signed [DEPTH_W-1:0] depth;
    } t_in;

    // Products and decoded conditions after the multiplier stage.
    typedef struct packed {
        logic                      zero_out;
        logic                      in_layer;
        logic                      inf;
        logic signed [DEPTH_W-1:0] z;
        logic        [CFG_W-1:0]   base;
        logic        [CFG_W-1:0]   bottom;
        logic signed [DEPTH_W-1:0] step_mixed;
        logic signed [DEPTH_W-1:0] step_deep;
        logic        [CFG_W-1:0]   place_layer;
        logic        [CFG_W-1:0]   place_column;
    } t_s1;

    // Depth after the layer move and the deep step.
    typedef struct packed {
        logic                      zero_out;
        logic                      inf;
        logic signed [DEPTH_W-1:0] z;
        logic        [CFG_W-1:0]   bottom;
        logic        [CFG_W-1:0]   place_column;
        logic signed [34:0]        total;
    } t_s2;

endpackage

// ----- design/vrwr_prod.sv -----
// Multiplier stage: scaled steps, placement products and decoded particle conditions.
module vrwr_prod import vrwr_pkg::*; (
    input  t_in  i_item,
    input  t_cfg i_cfg,
    output t_s1  o_s1
);

    logic signed [32:0] w_z;
    logic signed [32:0] w_ml;
    logic               w_in_layer;
    logic               w_inf;
    logic [CFG_W-1:0]   w_base;
    logic [CFG_W-1:0]   w_span;
    logic               w_apply_deep;
    logic signed [47:0] w_pm;
    logic signed [47:0] w_pd;
    logic signed [47:0] w_pm_adj;
    logic signed [47:0] w_pd_adj;
    logic [46:0]        w_pl;
    logic [46:0]        w_pc;

    always_comb begin
        w_z        = {i_item.depth[DEPTH_W-1], i_item.depth};
        w_ml       = {2'b00, i_cfg.mixed_layer};
        w_in_layer = (w_z <= w_ml);
        w_inf      = (i_cfg.bottom == '0) || (i_cfg.bottom == '1);
        // Inside the layer the base is pulled up to a shallower bottom.
        w_base     = (w_in_layer && !w_inf && (i_cfg.bottom < i_cfg.mixed_layer))
                     ? i_cfg.bottom : i_cfg.mixed_layer;
        w_apply_deep = (w_inf || (w_base != i_cfg.bottom)) && (i_cfg.amp_deep != '0);

        // Steps truncate toward zero, so negative products get a bias first.
        w_pm     = i_item.rand_mixed * $signed({17'b0, i_cfg.amp_mixed});
        w_pd     = i_item.rand_deep * $signed({17'b0, i_cfg.amp_deep});
        w_pm_adj = w_pm + (w_pm[47] ? 48'sd32767 : 48'sd0);
        w_pd_adj = w_pd + (w_pd[47] ? 48'sd32767 : 48'sd0);

        w_span = (i_cfg.bottom >= 31'd2) ? (i_cfg.bottom - 31'd2) : '0;
        w_pl   = {16'b0, w_base - 31'd1} * {31'b0, i_item.rand_place_layer};
        w_pc   = {16'b0, w_span} * {31'b0, i_item.rand_place_column};

        o_s1.zero_out     = (w_z <= 33'sd0) || (w_in_layer && (i_cfg.amp_mixed == '0));
        o_s1.in_layer     = w_in_layer;
        o_s1.inf          = w_inf;
        o_s1.z            = i_item.depth;
        o_s1.base         = w_base;
        o_s1.bottom       = i_cfg.bottom;
        o_s1.step_mixed   = w_pm_adj[46:15];
        o_s1.step_deep    = w_apply_deep ? w_pd_adj[46:15] : '0;
        o_s1.place_layer  = w_pl[46:16] + 31'd1;
        o_s1.place_column = w_pc[46:16] + 31'd1;
    end

endmodule

// ----- design/vrwr_layer.sv -----
// Layer stage: mixed-layer move with reflection at the base, then the deep step.
module vrwr_layer import vrwr_pkg::*; (
    input  t_s1 i_s1,
    output t_s2 o_s2
);

    logic signed [33:0] w_z;
    logic signed [33:0] w_base;
    logic signed [33:0] w_step;
    logic signed [33:0] w_t;
    logic signed [33:0] w_r;
    logic signed [33:0] w_d1;

    always_comb begin
        w_z    = 34'(i_s1.z);
        w_base = $signed({3'b000, i_s1.base});
        w_step = 34'(i_s1.step_mixed);
        w_t    = w_z + w_step;
        w_r    = (w_base <<< 1) - w_z - w_step;

        if (!i_s1.in_layer) begin
            w_d1 = w_z;
        end else if (w_t > w_base) begin
            // Reflected at the base; a reflection past the surface is placed in the layer.
            w_d1 = (w_r <= 34'sd0) ? $signed({3'b000, i_s1.place_layer}) : w_r;
        end else begin
            w_d1 = w_t;
        end

        o_s2.zero_out     = i_s1.zero_out;
        o_s2.inf          = i_s1.inf;
        o_s2.z            = i_s1.z;
        o_s2.bottom       = i_s1.bottom;
        o_s2.place_column = i_s1.place_column;
        o_s2.total        = 35'(w_d1) + 35'(i_s1.step_deep);
    end

endmodule

// ----- design/vrwr_check.sv -----
// Check stage: surface and bottom handling of the new depth and saturation of the move.
module vrwr_check import vrwr_pkg::*; (
    input  t_s2                       i_s2,
    output logic signed [DEPTH_W-1:0] o_change
);

    logic signed [36:0] w_t;
    logic signed [36:0] w_z;
    logic signed [36:0] w_b;
    logic signed [36:0] w_pc;
    logic signed [36:0] w_refl;
    logic signed [36:0] w_nd;
    logic signed [36:0] w_res;

    always_comb begin
        w_t    = 37'(i_s2.total);
        w_z    = 37'(i_s2.z);
        w_b    = $signed({6'b0, i_s2.bottom});
        w_pc   = $signed({6'b0, i_s2.place_column});
        w_refl = (w_b <<< 1) - w_t;

        priority if (w_t == 37'sd0) begin
            w_nd = 37'sd1;
        end else if (w_t < 37'sd0) begin
            // Reflected at the surface; past the bottom it is placed in the column.
            w_nd = (!i_s2.inf && ((w_t + w_b) < 37'sd0)) ? w_pc : -w_t;
        end else if (!i_s2.inf && (w_t == w_b)) begin
            w_nd = w_b - 37'sd1;
        end else if (!i_s2.inf && (w_t > w_b)) begin
            w_nd = (w_refl <= 37'sd0) ? w_pc : w_refl;
        end else begin
            w_nd = w_t;
        end

        w_res = w_nd - w_z;

        if (i_s2.zero_out) begin
            o_change = '0;
        end else if (w_res > 37'sd2147483647) begin
            o_change = 32'sh7FFF_FFFF;
        end else if (w_res < -37'sd2147483648) begin
            o_change = 32'sh8000_0000;
        end else begin
            o_change = w_res[DEPTH_W-1:0];
        end
    end

endmodule

// ----- design/vertical_random_walk_reflect.sv -----
// Vertical random walk with reflection: top level with configuration and stage registers.
// Throughput: one transaction per cycle while the result stream does not stall, set by
// the four-register pipeline of input, multiplier, layer and check stages, each of which
// takes a new item every cycle unless stalled; results leave from the check register.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults:
// mixed layer 10000000, bottom 2147483647 (infinitely deep), both amplitudes zero.
module vertical_random_walk_reflect import vrwr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input stream; tdata fields from bit 0 up: depth[31:0], rand_mixed[47:32],
    // rand_deep[63:48], rand_place_layer[79:64], rand_place_column[95:80].
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [IN_W-1:0]     s_axis_tdata,
    // Result stream; tdata fields from bit 0 up: depth_change[31:0].
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [DEPTH_W-1:0]  m_axis_tdata,
    // Configuration write channel, index follows the register list order.
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    t_in  r_s0;
    t_s1  r_s1;
    t_s2  r_s2;
    logic [DEPTH_W-1:0] r_res;

    logic r_v0;
    logic r_v1;
    logic r_v2;
    logic r_v3;

    t_s1  w_s1;
    t_s2  w_s2;
    logic signed [DEPTH_W-1:0] w_change;

    logic w_en0;
    logic w_en1;
    logic w_en2;
    logic w_en3;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MIXED_LAYER_DEPTH: n_cfg.mixed_layer = i_cfg_data;
                CFG_BOTTOM_DEPTH:      n_cfg.bottom      = i_cfg_data;
                CFG_MIXED_STEP_AMP:    n_cfg.amp_mixed   = i_cfg_data;
                CFG_DEEP_STEP_AMP:     n_cfg.amp_deep    = i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mixed_layer <= MIXED_LAYER_RST;
            r_cfg.bottom      <= BOTTOM_RST;
            r_cfg.amp_mixed   <= AMP_RST;
            r_cfg.amp_deep    <= AMP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Each stage moves when it is empty or the stage after it moves, so bubbles
    // are squeezed out. A waiting result stalls an earlier stage only when every
    // stage between them is full.
    assign w_en3 = !r_v3 || m_axis_tready;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign w_en0 = !r_v0 || w_en1;

    assign s_axis_tready = w_en0;
    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en0) r_v0 <= s_axis_tvalid;
            if (w_en1) r_v1 <= r_v0;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en0) r_s0  <= t_in'(s_axis_tdata);
        if (w_en1) r_s1  <= w_s1;
        if (w_en2) r_s2  <= w_s2;
        if (w_en3) r_res <= w_change;
    end

    // Products of the draws with the amplitudes and the placement fractions.
    vrwr_prod u_prod (
        .i_item (r_s0),
        .i_cfg  (r_cfg),
        .o_s1   (w_s1)
    );

    // Move inside the mixed layer, then the deep step.
    vrwr_layer u_layer (
        .i_s1 (r_s1),
        .o_s2 (w_s2)
    );

    // Surface and bottom checks, displacement and saturation.
    vrwr_check u_check (
        .i_s2     (r_s2),
        .o_change (w_change)
    );

endmodule

// ----- tb/vertical_random_walk_reflect_tb.sv -----
// Self-checking testbench for the vertical random walk with reflection block.
module vertical_random_walk_reflect_tb import vrwr_pkg::*; ();

    // Limits of the signed 32-bit displacement.
    localparam longint DEPTH_TOP      = 64'sd2147483647;
    localparam longint DEPTH_BOTTOM   = -64'sd2147483648;
    // Cycles with no transaction on any channel before the run is declared hung.
    localparam int     WATCHDOG_LIMIT = 2000;
    // Tail wait after the drain, to catch a stray result still in the pipeline.
    localparam int     DRAIN_TAIL     = 8;

    // Receiver behaviors, switched among at random by the receiver process.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_LIGHT,
        RX_HALF,
        RX_BURSTY
    } t_rx_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    // Fields from bit 0 up: depth, rand_mixed, rand_deep, rand_place_layer, rand_place_column.
    logic [IN_W-1:0]    s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // Fields from bit 0 up: depth_change.
    logic [DEPTH_W-1:0] m_axis_tdata;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    t_cfg_idx           i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;

    // Shadow copy of the configuration, updated on each accepted register write.
    logic [CFG_W-1:0] reg_mixed_layer = MIXED_LAYER_RST;
    logic [CFG_W-1:0] reg_bottom      = BOTTOM_RST;
    logic [CFG_W-1:0] reg_amp_mixed   = AMP_RST;
    logic [CFG_W-1:0] reg_amp_deep    = AMP_RST;

    // Displacements predicted for accepted particles, oldest first.
    logic signed [DEPTH_W-1:0] expected_change[$];
    int                        error_count = 0;
    int                        idle_cycles = 0;

    t_rx_mode rx_mode;
    int       rx_left = 0;

    vertical_random_walk_reflect dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Computes the displacement of one particle under the current shadow configuration.
    // All intermediate values are held in 64 bits so that nothing wraps before the
    // final saturation.
    function automatic logic signed [DEPTH_W-1:0] predict_depth_change(input t_in p);
        longint z, rm, rd, pl, pc, ml, bot, amp_m, amp_d;
        longint base, acc, moved, total, res, column;
        bit     unbounded;
        z     = longint'(p.depth);
        rm    = longint'(p.rand_mixed);
        rd    = longint'(p.rand_deep);
        pl    = longint'(p.rand_place_layer);
        pc    = longint'(p.rand_place_column);
        ml    = longint'(reg_mixed_layer);
        bot   = longint'(reg_bottom);
        amp_m = longint'(reg_amp_mixed);
        amp_d = longint'(reg_amp_deep);
        // A bottom of zero or of the largest value stands for infinitely deep water.
        unbounded = (bot == 0) || (bot == DEPTH_TOP);
        base = ml;
        acc  = 0;
        // Column placement lands in [1, bottom - 1), or at 1 for a one-micrometre bottom.
        column = 1 + ((((bot >= 2) ? bot - 2 : 0) * pc) >> 16);

        if (z <= 0)
            return '0;
        if (z <= ml) begin
            if (amp_m == 0)
                return '0;
            // The reflecting base is the shallower of the layer base and the bottom.
            if (!unbounded && bot < base)
                base = bot;
            acc   = (rm * amp_m) / 32768;
            moved = z + acc;
            if (moved > base) begin
                acc = 2 * base - moved - z;
                // Reflected through the surface: random placement inside the layer.
                if (z + acc <= 0)
                    acc = 1 + (((base - 1) * pl) >> 16) - z;
            end
        end
        // The deep step is skipped when the layer base coincides with a finite bottom or the deep amplitude is zero.
        if ((unbounded || base != bot) && amp_d != 0)
            acc += (rd * amp_d) / 32768;
        total = z + acc;

        if (total == 0) begin
            res = 1 - z;
        end else if (total < 0) begin
            res = -total - z;
            if (!unbounded && -total > bot)
                res = column - z;
        end else if (!unbounded && total == bot) begin
            res = bot - 1 - z;
        end else if (!unbounded && total > bot) begin
            res = 2 * bot - total - z;
            if (2 * bot - total <= 0)
                res = column - z;
        end else begin
            res = acc;
        end

        if (res > DEPTH_TOP)
            res = DEPTH_TOP;
        if (res < DEPTH_BOTTOM)
            res = DEPTH_BOTTOM;
        return res[DEPTH_W-1:0];
    endfunction

    function automatic t_in make_particle(input logic signed [DEPTH_W-1:0] depth,
                                          input logic signed [RAND_W-1:0]  rm,
                                          input logic signed [RAND_W-1:0]  rd,
                                          input logic        [RAND_W-1:0]  pl,
                                          input logic        [RAND_W-1:0]  pc);
        t_in p;
        p.depth             = depth;
        p.rand_mixed        = rm;
        p.rand_deep         = rd;
        p.rand_place_layer  = pl;
        p.rand_place_column = pc;
        return p;
    endfunction

    // Picks a depth that lands near the interesting regions of the current setup:
    // inside the layer, between layer and bottom, on the boundaries, or anywhere.
    function automatic logic signed [DEPTH_W-1:0] pick_depth();
        longint      ml, deep_end, lo;
        int unsigned sel;
        ml       = longint'(reg_mixed_layer);
        deep_end = (reg_bottom == BOTTOM_RST) ? ml * 2 + 1000 : longint'(reg_bottom);
        if (deep_end > DEPTH_TOP)
            deep_end = DEPTH_TOP;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            return $urandom;
        if (sel < 22) begin
            case ($urandom_range(0, 5))
                0:       return 0;
                1:       return 1;
                2:       return 32'(ml);
                3:       return 32'(ml + 1);
                4:       return 32'(deep_end - 1);
                default: return 32'(deep_end);
            endcase
        end
        if (sel < 62 && ml >= 1)
            return $urandom_range(32'(ml), 1);
        lo = (ml < deep_end) ? ml + 1 : 1;
        return $urandom_range(32'(deep_end), 32'(lo));
    endfunction

    function automatic logic [CFG_W-1:0] pick_amp(input longint scale);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return CFG_W'($urandom_range(32'(scale), 1));
            2:       return CFG_W'($urandom_range(32'h7fff_ffff, 0));
            default: return DEPTH_TOP[CFG_W-1:0];
        endcase
    endfunction

    // Presents one particle and returns at the edge where it is accepted. tvalid is
    // left high, so a following call keeps the stream going without a bubble.
    task automatic send_particle(input t_in p);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Stops the input stream and waits until every predicted result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_change.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Registers are only rewritten once the pipeline holds no particle.
    task automatic set_config(input logic [CFG_W-1:0] layer, input logic [CFG_W-1:0] bottom,
                              input logic [CFG_W-1:0] amp_m, input logic [CFG_W-1:0] amp_d);
        wait_drained();
        write_reg(CFG_MIXED_LAYER_DEPTH, layer);
        write_reg(CFG_BOTTOM_DEPTH, bottom);
        write_reg(CFG_MIXED_STEP_AMP, amp_m);
        write_reg(CFG_DEEP_STEP_AMP, amp_d);
    endtask

    // With reset values both amplitudes are zero: every particle keeps its depth.
    task automatic test_reset_defaults();
        send_particle(make_particle(32'sh8000_0000, -32768, -32768, 0, 0));
        send_particle(make_particle(0, 32767, 32767, 65535, 65535));
        send_particle(make_particle(1, 32767, -32768, 0, 65535));
        send_particle(make_particle(10000000, -32768, 32767, 65535, 0));
        send_particle(make_particle(10000001, 32767, 32767, 65535, 65535));
        send_particle(make_particle(32'sh7fff_ffff, 32767, 32767, 65535, 65535));
        wait_drained();
    endtask

    // Unbounded water, mixed step only: reflection at the base, placement inside the
    // layer at both ends of the fraction, reflection at the surface and the exact hit.
    task automatic test_mixed_layer();
        set_config(1000, BOTTOM_RST, 2000, 0);
        send_particle(make_particle(900, 32767, 0, 0, 0));
        send_particle(make_particle(900, 32767, 0, 65535, 0));
        send_particle(make_particle(10, -32768, 0, 0, 0));
        send_particle(make_particle(500, -8192, 0, 0, 0));
        send_particle(make_particle(1000, 100, 0, 0, 0));
        wait_drained();
    endtask

    // Finite bottoms: reflection off the bottom, the nudges off exact surface and
    // bottom hits, random placement in the column, a bottom shallower than the layer
    // and a one-micrometre bottom.
    task automatic test_bottom_checks();
        set_config(1000, 5000, 0, 4000);
        send_particle(make_particle(3000, 0, 32767, 0, 0));
        send_particle(make_particle(3000, 0, 16384, 0, 0));
        send_particle(make_particle(1500, 0, -12288, 0, 0));
        send_particle(make_particle(800, 32767, 32767, 0, 0));
        set_config(1000, 5000, 0, DEPTH_TOP[CFG_W-1:0]);
        send_particle(make_particle(1500, 0, -32768, 0, 65535));
        send_particle(make_particle(3000, 0, 32767, 0, 0));
        set_config(1000, 600, 300, 4000);
        send_particle(make_particle(500, 32767, 32767, 0, 0));
        set_config(0, 1, 0, 50);
        send_particle(make_particle(5, 0, 32767, 0, 65535));
        send_particle(make_particle(5, 0, -32768, 0, 65535));
        send_particle(make_particle(3, 0, -1311, 0, 0));
        wait_drained();
    endtask

    // Every register at its maximum: both steps add up past the 32-bit range.
    task automatic test_saturation();
        set_config(DEPTH_TOP[CFG_W-1:0], DEPTH_TOP[CFG_W-1:0],
                   DEPTH_TOP[CFG_W-1:0], DEPTH_TOP[CFG_W-1:0]);
        send_particle(make_particle(1, 32767, 32767, 0, 0));
        send_particle(make_particle(1, -32768, -32768, 0, 0));
        send_particle(make_particle(32'sh7fff_ffff, 32767, 32767, 65535, 65535));
        wait_drained();
    endtask

    // Random particles in bursts over several configurations. The first two are a
    // typical setup and the all-maximum corner, the rest are drawn at random.
    task automatic test_random_walk();
        logic [CFG_W-1:0] layer, bottom;
        longint           bot_pick, scale;
        int               burst_left, gap_max;
        t_in              p;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    layer  = 10000000;
                    bottom = 30000000;
                end
                1: begin
                    layer  = DEPTH_TOP[CFG_W-1:0];
                    bottom = DEPTH_TOP[CFG_W-1:0];
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0:       layer = 0;
                        1:       layer = CFG_W'($urandom_range(1000, 1));
                        2:       layer = CFG_W'($urandom_range(10000000, 1000));
                        3:       layer = CFG_W'($urandom_range(32'h7fff_ffff, 0));
                        default: layer = DEPTH_TOP[CFG_W-1:0];
                    endcase
                    case ($urandom_range(0, 4))
                        0:       bot_pick = longint'($urandom_range(2, 1));
                        1:       bot_pick = longint'(layer) +
                                            longint'($urandom_range(20000, 0));
                        2:       bot_pick = longint'($urandom_range(32'h7fff_fffe, 1));
                        3:       bot_pick = longint'($urandom_range(
                                                32'(longint'(layer) + 1), 1));
                        default: bot_pick = DEPTH_TOP;
                    endcase
                    if (bot_pick > DEPTH_TOP)
                        bot_pick = DEPTH_TOP;
                    bottom = bot_pick[CFG_W-1:0];
                end
            endcase
            scale = (layer > 1000) ? longint'(layer) : 1000;
            if (phase == 0)
                set_config(layer, bottom, 400000, 100000);
            else if (phase == 1)
                set_config(layer, bottom, DEPTH_TOP[CFG_W-1:0], DEPTH_TOP[CFG_W-1:0]);
            else
                set_config(layer, bottom, pick_amp(scale), pick_amp(scale));

            // One phase streams without any sender gap.
            gap_max    = (phase == 2) ? 0 : 6;
            burst_left = $urandom_range(16, 1);
            for (int n = 0; n < 80; n++) begin
                p.depth             = pick_depth();
                p.rand_mixed        = RAND_W'($urandom);
                p.rand_deep         = RAND_W'($urandom);
                p.rand_place_layer  = RAND_W'($urandom);
                p.rand_place_column = RAND_W'($urandom);
                send_particle(p);
                // Mid-stream, hold off until the pipeline has fully emptied.
                if (phase == 3 && n == 40)
                    wait_drained();
                burst_left--;
                if (burst_left == 0) begin
                    idle_sender($urandom_range(gap_max, 0));
                    burst_left = $urandom_range(16, 1);
                end
            end
        end
        wait_drained();
    endtask

    // The receiver switches its stall behavior at random; one of the behaviors never
    // stalls, another holds tready low in regular runs.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(3, 0));
            rx_left = $urandom_range(120, 20);
        end
        rx_left--;
        case (rx_mode)
            RX_ALWAYS: m_axis_tready <= 1'b1;
            RX_LIGHT:  m_axis_tready <= ($urandom_range(3, 0) != 0);
            RX_HALF:   m_axis_tready <= ($urandom_range(1, 0) != 0);
            default:   m_axis_tready <= ((rx_left % 12) < 4);
        endcase
    end

    // Monitor: tracks register writes, predicts each accepted particle, checks each
    // accepted result against the oldest prediction, and runs the hang watchdog.
    always @(posedge i_clk) begin
        logic signed [DEPTH_W-1:0] want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIXED_LAYER_DEPTH: reg_mixed_layer = i_cfg_data;
                    CFG_BOTTOM_DEPTH:      reg_bottom      = i_cfg_data;
                    CFG_MIXED_STEP_AMP:    reg_amp_mixed   = i_cfg_data;
                    CFG_DEEP_STEP_AMP:     reg_amp_deep    = i_cfg_data;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_change.push_back(predict_depth_change(t_in'(s_axis_tdata)));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_change.size() == 0) begin
                    $error("depth_change: unexpected result transaction, actual %0d",
                           $signed(m_axis_tdata));
                    error_count++;
                end else begin
                    want = expected_change.pop_front();
                    if (m_axis_tdata !== want) begin
                        $error("depth_change mismatch: expected %0d, actual %0d",
                               want, $signed(m_axis_tdata));
                        error_count++;
                    end
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_MIXED_LAYER_DEPTH;
        i_cfg_data    = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_mixed_layer();
        test_bottom_checks();
        test_saturation();
        test_random_walk();

        // Everything predicted has arrived; watch for stray results over the tail wait.
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
